/* rtl/core/trial_division_primality_core_assert.svh */
// ----------------------------------------------------------------------------
// trial_division_primality_core_assert.svh
// assertion macros for the trial division primality core
// ----------------------------------------------------------------------------
`ifndef TRIAL_DIVISION_PRIMALITY_CORE_ASSERT_SVH
`define TRIAL_DIVISION_PRIMALITY_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define TDP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define TDP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`else

`define TDP_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define TDP_ASSERT_NXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* rtl/core/tdp_pkg.sv */
// ----------------------------------------------------------------------------
// tdp_pkg
// shared constants and types of the trial division primality core
// ----------------------------------------------------------------------------
package tdp_pkg;

    // default operand width
    localparam int VALUE_WIDTH_DEF = 32;

    // verdict codes
    typedef logic [1:0] verdict_t;
    localparam verdict_t VERDICT_PRIME     = 2'd0;
    localparam verdict_t VERDICT_COMPOSITE = 2'd1;
    localparam verdict_t VERDICT_NEGATIVE  = 2'd2;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

/* rtl/core/tdp_divider.sv */
// ----------------------------------------------------------------------------
// tdp_divider
// restoring radix-2 divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module tdp_divider #(
    parameter int MAG_WIDTH = tdp_pkg::VALUE_WIDTH_DEF - 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [MAG_WIDTH-1:0]  dividend,
    input  logic [MAG_WIDTH-1:0]  divisor,
    output logic [MAG_WIDTH-1:0]  quotient,
    output logic [MAG_WIDTH-1:0]  remainder,
    output tdp_pkg::div_stat_t    stat
);
    import tdp_pkg::*;

    localparam int CNT_WIDTH = $clog2(MAG_WIDTH + 1);

    logic [MAG_WIDTH-1:0] rem_reg;
    logic [MAG_WIDTH-1:0] quo_reg;
    logic [MAG_WIDTH-1:0] den_reg;
    logic [CNT_WIDTH-1:0] cnt_reg;
    logic                 busy_reg;
    logic                 done_reg;
    logic [MAG_WIDTH:0]   trial_next;

    // shared subtractor: partial remainder with next dividend bit, minus divisor
    assign trial_next = {rem_reg, quo_reg[MAG_WIDTH-1]} - {1'b0, den_reg};

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            // done pulses once, right after the last quotient bit
            done_reg <= busy_reg && !start && (cnt_reg == CNT_WIDTH'(1));
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_WIDTH'(MAG_WIDTH);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_WIDTH'(1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // datapath: shift, compare and restore
    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= '0;
            quo_reg <= dividend;
            den_reg <= divisor;
        end else if (busy_reg) begin
            if (!trial_next[MAG_WIDTH]) begin
                rem_reg <= trial_next[MAG_WIDTH-1:0];
                quo_reg <= {quo_reg[MAG_WIDTH-2:0], 1'b1};
            end else begin
                rem_reg <= {rem_reg[MAG_WIDTH-2:0], quo_reg[MAG_WIDTH-1]};
                quo_reg <= {quo_reg[MAG_WIDTH-2:0], 1'b0};
            end
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

/* rtl/core/trial_division_primality_core.sv */
// ----------------------------------------------------------------------------
// trial_division_primality_core
// classifies a signed integer as prime, not prime or negative
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_valid/s_ready/s_value carries one two's complement value.
//   Result channel m_valid/m_ready/m_verdict returns one verdict per value:
//   0 prime, 1 not prime (0 and 1 included), 2 negative input.
//   s_ready is high only while the sequencer is idle; one value is in work
//   at a time. A negative value, 0 or 1 is classified without the divider.
//   Otherwise divisors d = 2, 3, ... are tried while d <= value / d, each
//   trial running in the one shared restoring divider (a start step,
//   VALUE_WIDTH - 1 quotient bits and a decision step).
//   Worst case at 32 bits is a large prime: about 46341 trials.
//   The verdict sits in an output register; a new value may be transferred
//   while it waits. If the receiver stalls and a new verdict is ready, the
//   sequencer holds it until the output register frees up.
//   Reset (aresetn low, synchronous) drops any value in work and any
//   pending verdict.
// ----------------------------------------------------------------------------
`include "trial_division_primality_core_assert.svh"

module trial_division_primality_core #(
    parameter int VALUE_WIDTH = tdp_pkg::VALUE_WIDTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [VALUE_WIDTH-1:0] s_value,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_verdict
);
    import tdp_pkg::*;

    localparam int MAG_WIDTH = VALUE_WIDTH - 1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    state_t               state_reg;
    logic [MAG_WIDTH-1:0] value_reg;
    logic [MAG_WIDTH-1:0] d_reg;
    logic [MAG_WIDTH-1:0] d_next;
    logic                 start_reg;
    verdict_t             verdict_reg;
    logic                 m_valid_reg;
    verdict_t             m_verdict_reg;
    logic [MAG_WIDTH-1:0] div_quo;
    logic [MAG_WIDTH-1:0] div_rem;
    div_stat_t            div_stat;

    // shared divider
    tdp_divider #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_divider (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (start_reg),
        .dividend  (value_reg),
        .divisor   (d_reg),
        .quotient  (div_quo),
        .remainder (div_rem),
        .stat      (div_stat)
    );

    assign d_next = d_reg + 1'b1;

    // sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            start_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // finish state reloads the output register itself
            if (m_valid_reg && m_ready && state_reg != ST_FINISH) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        value_reg <= s_value[MAG_WIDTH-1:0];
                        d_reg     <= MAG_WIDTH'(2);
                        if (s_value[VALUE_WIDTH-1]) begin
                            verdict_reg <= VERDICT_NEGATIVE;
                            state_reg   <= ST_FINISH;
                        end else if (s_value[MAG_WIDTH-1:1] == '0) begin
                            verdict_reg <= VERDICT_COMPOSITE;
                            state_reg   <= ST_FINISH;
                        end else begin
                            start_reg <= 1'b1;
                            state_reg <= ST_DIVIDE;
                        end
                    end
                end
                ST_DIVIDE: begin
                    // bound check, then remainder check, then next divisor
                    if (div_stat.done) begin
                        if (d_reg > div_quo) begin
                            verdict_reg <= VERDICT_PRIME;
                            state_reg   <= ST_FINISH;
                        end else if (div_rem == '0) begin
                            verdict_reg <= VERDICT_COMPOSITE;
                            state_reg   <= ST_FINISH;
                        end else begin
                            d_reg     <= d_next;
                            start_reg <= 1'b1;
                        end
                    end else begin
                        start_reg <= 1'b0;
                    end
                end
                ST_FINISH: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg   <= 1'b1;
                        m_verdict_reg <= verdict_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_verdict = m_verdict_reg;

    // divider finishes only while the sequencer waits on it
    `TDP_ASSERT_IMP(a_done_in_divide, aclk, aresetn, div_stat.done, state_reg == ST_DIVIDE)
    // a start always sets the divider busy
    `TDP_ASSERT_NXT(a_start_busy, aclk, aresetn, start_reg, div_stat.busy)
    // trial divisor never drops below two while dividing
    `TDP_ASSERT_IMP(a_divisor_min, aclk, aresetn, state_reg == ST_DIVIDE, d_reg >= MAG_WIDTH'(2))
    // the divider is idle whenever a new value can be transferred
    `TDP_ASSERT_IMP(a_ready_idle, aclk, aresetn, s_ready, !div_stat.busy && !start_reg)

endmodule
